// File: sv/bvas_pkg.sv
// bvas_pkg: shared constants, operation codes and control structs for the
// bit-vector arithmetic and shift unit. No dependencies.
package bvas_pkg;

  localparam int WIDTH  = 32;                // bit-vector width
  localparam int DATA_W = 32;                // operand / result port width
  localparam int ADD_W  = WIDTH + 1;         // shared adder width
  localparam int SH_W   = $clog2(WIDTH);     // in-range shift amount bits
  localparam int CNT_W  = $clog2(WIDTH);     // step counter bits
  localparam int ACT_W  = 4;

  localparam logic [ACT_W-1:0] ACT_ADD  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_MUL  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_UDIV = 4'd2;
  localparam logic [ACT_W-1:0] ACT_UREM = 4'd3;
  localparam logic [ACT_W-1:0] ACT_SDIV = 4'd4;
  localparam logic [ACT_W-1:0] ACT_SREM = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SMOD = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SHL  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_LSHR = 4'd8;
  localparam logic [ACT_W-1:0] ACT_ASHR = 4'd9;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [ADD_W-1:0] add_word_t;

  // shifter direction / fill select
  typedef struct packed {
    logic left;
    logic arith;
  } shift_ctl_t;

  // shared adder operands
  typedef struct packed {
    add_word_t x;
    add_word_t y;
    logic      sub;
  } addsub_req_t;

endpackage

// File: sv/bvas_addsub.sv
// bvas_addsub: shared add / subtract unit, one WIDTH+1 bit carry chain.
// Depends on bvas_pkg.
module bvas_addsub import bvas_pkg::*; (
  input  addsub_req_t req,
  output add_word_t   sum,
  output logic        cout   // carry out; for a subtract, 1 means no borrow
);

  logic [ADD_W:0] full;

  assign full = {1'b0, req.x} + {1'b0, req.y ^ {ADD_W{req.sub}}} + {{ADD_W{1'b0}}, req.sub};
  assign sum  = full[ADD_W-1:0];
  assign cout = full[ADD_W];

endmodule

// File: sv/bvas_shifter.sv
// bvas_shifter: barrel shifter for shl, lshr and ashr with SMT-LIB
// overshift handling. Depends on bvas_pkg.
module bvas_shifter import bvas_pkg::*; (
  input  word_t      value,
  input  word_t      amount,
  input  shift_ctl_t ctl,
  output word_t      shifted
);

  localparam word_t WIDTH_V = word_t'(WIDTH);

  logic            fill;
  logic            over;
  logic [SH_W-1:0] sh;

  assign fill = !ctl.left && ctl.arith && value[WIDTH-1];
  assign over = (amount >= WIDTH_V);
  assign sh   = amount[SH_W-1:0];

  always_comb begin
    if (over) begin
      shifted = {WIDTH{fill}};
    end else if (ctl.left) begin
      shifted = value << sh;
    end else if (ctl.arith) begin
      shifted = word_t'($signed(value) >>> sh);
    end else begin
      shifted = value >> sh;
    end
  end

endmodule

// File: sv/bitvector_arith_shift_unit.sv
// bitvector_arith_shift_unit: top level, sequencer and output register.
// Depends on bvas_pkg, bvas_addsub and bvas_shifter.
//
// Takes one request (action, operand_a, operand_b) at a time and returns one
// result with SMT-LIB bit-vector semantics. Add, unused codes and the three
// shifts pass through S_SIMPLE and S_FINISH before out_valid rises. Multiply is
// shift-add, one multiplier bit a cycle through the shared adder, then
// S_FINISH. Divide, remainder and modulo go through two magnitude steps, WIDTH
// restoring steps, a sign-fix step and, for smod with operands of opposite
// sign and a nonzero remainder, one more adjust step, then S_FINISH. in_ready
// returns on the edge that raises out_valid, so the next request can be taken
// while that result is presented. A finished result waits in the sequencer
// until the output register is free, so a stalled receiver also holds off the
// next request. Every step of the arithmetic goes through one shared WIDTH+1
// bit adder. in_ready is high whenever the sequencer is idle, even while a
// finished result waits in the output register. A zero divisor raises
// divide_by_zero: quotients are then all ones (sdiv with a negative dividend
// gives 1) and remainders/modulo return operand_a.
module bitvector_arith_shift_unit import bvas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_result,
  output logic              out_divide_by_zero
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIMPLE = 4'd1;  // add, shifts, unused codes
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ABS_A  = 4'd3;
  localparam logic [3:0] S_ABS_B  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_FIX    = 4'd6;  // sign correction of q / r
  localparam logic [3:0] S_MODADJ = 4'd7;  // smod: add divisor back
  localparam logic [3:0] S_FINISH = 4'd8;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic [3:0]       state_r, state_nxt;
  logic [ACT_W-1:0] op_r, op_nxt;
  word_t            a_r, a_nxt;      // multiplicand / dividend as received
  word_t            b_r, b_nxt;      // multiplier src / divisor magnitude
  word_t            acc_r, acc_nxt;  // product / partial remainder
  word_t            q_r, q_nxt;      // multiplier bits / dividend -> quotient
  word_t            res_r, res_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             na_r, na_nxt;
  logic             nb_r, nb_nxt;
  logic             dz_r, dz_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_result_r, out_result_nxt;
  logic              out_dz_r, out_dz_nxt;

  addsub_req_t add_req;
  add_word_t   add_sum;
  logic        add_cout;
  shift_ctl_t  sh_ctl;
  word_t       sh_out;

  word_t in_a, in_b;
  logic  accept;
  logic  is_div, is_signed;
  logic  out_free;
  word_t fix_val;
  logic  fix_neg;

  assign in_a     = word_t'(in_operand_a);
  assign in_b     = word_t'(in_operand_b);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign is_div    = (in_action inside {ACT_UDIV, ACT_UREM, ACT_SDIV, ACT_SREM, ACT_SMOD});
  assign is_signed = (in_action inside {ACT_SDIV, ACT_SREM, ACT_SMOD});

  // shared adder and shifter
  bvas_addsub u_addsub (
    .req  (add_req),
    .sum  (add_sum),
    .cout (add_cout)
  );

  assign sh_ctl.left  = (op_r == ACT_SHL);
  assign sh_ctl.arith = (op_r == ACT_ASHR);

  bvas_shifter u_shifter (
    .value   (a_r),
    .amount  (b_r),
    .ctl     (sh_ctl),
    .shifted (sh_out)
  );

  // value to sign-correct at the end of a divide
  always_comb begin
    case (op_r)
      ACT_UDIV: begin fix_val = q_r;   fix_neg = 1'b0;        end
      ACT_SDIV: begin fix_val = q_r;   fix_neg = na_r ^ nb_r; end
      ACT_UREM: begin fix_val = acc_r; fix_neg = 1'b0;        end
      default:  begin fix_val = acc_r; fix_neg = na_r;        end  // srem, smod
    endcase
  end

  // adder operand select per step
  always_comb begin
    add_req = '0;
    case (state_r)
      S_SIMPLE: begin
        add_req.x = {1'b0, a_r};
        add_req.y = {1'b0, b_r};
      end
      S_MUL: begin
        add_req.x = {1'b0, acc_r};
        add_req.y = q_r[0] ? {1'b0, a_r} : '0;
      end
      S_ABS_A: begin
        add_req.y   = {1'b0, a_r};
        add_req.sub = 1'b1;
      end
      S_ABS_B: begin
        add_req.y   = {1'b0, b_r};
        add_req.sub = 1'b1;
      end
      S_DIV: begin
        add_req.x   = {acc_r, q_r[WIDTH-1]};
        add_req.y   = {1'b0, b_r};
        add_req.sub = 1'b1;
      end
      S_FIX: begin
        add_req.y   = {1'b0, fix_val};
        add_req.sub = 1'b1;
      end
      S_MODADJ: begin
        add_req.x   = {1'b0, res_r};
        add_req.y   = {1'b0, b_r};
        add_req.sub = nb_r;
      end
      default: add_req = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    q_nxt          = q_r;
    res_nxt        = res_r;
    cnt_nxt        = cnt_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    dz_nxt         = dz_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_dz_nxt     = out_dz_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_action;
          a_nxt   = in_a;
          b_nxt   = in_b;
          q_nxt   = in_b;
          acc_nxt = '0;
          cnt_nxt = '0;
          na_nxt  = is_signed && in_a[WIDTH-1];
          nb_nxt  = is_signed && in_b[WIDTH-1];
          dz_nxt  = is_div && (in_b == '0);
          if (in_action == ACT_MUL) begin
            state_nxt = S_MUL;
          end else if (is_div) begin
            state_nxt = S_ABS_A;
          end else begin
            state_nxt = S_SIMPLE;
          end
        end
      end
      S_SIMPLE: begin
        case (op_r)
          ACT_ADD:                     res_nxt = add_sum[WIDTH-1:0];
          ACT_SHL, ACT_LSHR, ACT_ASHR: res_nxt = sh_out;
          default:                     res_nxt = '0;
        endcase
        state_nxt = S_FINISH;
      end
      S_MUL: begin
        acc_nxt = add_sum[WIDTH-1:0];
        a_nxt   = a_r << 1;
        q_nxt   = q_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          res_nxt   = add_sum[WIDTH-1:0];
          state_nxt = S_FINISH;
        end
      end
      S_ABS_A: begin
        q_nxt     = na_r ? add_sum[WIDTH-1:0] : a_r;
        state_nxt = S_ABS_B;
      end
      S_ABS_B: begin
        if (nb_r) begin
          b_nxt = add_sum[WIDTH-1:0];
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring step: keep the difference when there is no borrow
        if (add_cout) begin
          acc_nxt = add_sum[WIDTH-1:0];
        end else begin
          acc_nxt = {acc_r[WIDTH-2:0], q_r[WIDTH-1]};
        end
        q_nxt   = {q_r[WIDTH-2:0], add_cout};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        res_nxt = fix_neg ? add_sum[WIDTH-1:0] : fix_val;
        if (op_r == ACT_SMOD && (na_r ^ nb_r) && (acc_r != '0)) begin
          state_nxt = S_MODADJ;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MODADJ: begin
        res_nxt   = add_sum[WIDTH-1:0];
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = DATA_W'(res_r);
          out_dz_nxt     = dz_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    acc_r        <= acc_nxt;
    q_r          <= q_nxt;
    res_r        <= res_nxt;
    cnt_r        <= cnt_nxt;
    na_r         <= na_nxt;
    nb_r         <= nb_nxt;
    dz_r         <= dz_nxt;
    out_result_r <= out_result_nxt;
    out_dz_r     <= out_dz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_divide_by_zero = out_dz_r;

`ifndef NO_ASSERTIONS
  // in_ready is low in the cycle after a request is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("in_ready high straight after a request was accepted");

  // a finished result is loaded into a free output register
  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && out_free |=> out_valid && (state_r == S_IDLE))
    else $error("finished result not presented");

  // zero-divisor flag only for divide, remainder and modulo
  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && dz_r |-> (op_r == ACT_UDIV) || (op_r == ACT_UREM) ||
      (op_r == ACT_SDIV) || (op_r == ACT_SREM) || (op_r == ACT_SMOD))
    else $error("divide_by_zero raised for a non-divide operation");
`endif

endmodule
